// ===== design/bst_pkg.sv =====
// Shared types and constants for the bencode stream tokenizer.
`timescale 1ns / 1ps

package bst_pkg;

  // Event kinds carried in event_kind.
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_DICT_OPEN = 3'd1;
  localparam logic [2:0] EV_LIST_OPEN = 3'd2;
  localparam logic [2:0] EV_CLOSE     = 3'd3;
  localparam logic [2:0] EV_INTEGER   = 3'd4;
  localparam logic [2:0] EV_STR_HDR   = 3'd5;
  localparam logic [2:0] EV_STR_BYTE  = 3'd6;
  localparam logic [2:0] EV_ERROR     = 3'd7;

  // Error codes carried in error_code.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
  localparam logic [2:0] ERR_NO_DIGITS  = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW   = 3'd3;
  localparam logic [2:0] ERR_TOO_DEEP   = 3'd4;

  // Syntax characters.
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_END   = 8'h65;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DICT  = 8'h64;
  localparam logic [7:0] CH_LIST  = 8'h6C;
  localparam logic [7:0] CH_INT   = 8'h69;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         event_kind;
    logic signed [63:0] event_value;
    logic               is_dict_key;
    logic [5:0]         nesting_depth;
    logic               string_last;
    logic [2:0]         error_code;
    logic               value_complete;
  } out_item_t;

endpackage

// ===== design/bencode_stream_tokenizer.sv =====
// Top level of the bencode stream tokenizer: byte parser, container stack memory, output register.
`timescale 1ns / 1ps

// The event for a byte is written into the output register at the edge where the byte is taken.
// Throughput: one byte per cycle unless the output stalls; the stack top lives in flops and the
// entry beneath it is prefetched from the stack memory, so consecutive pushes and pops never stall.
// Reset (synchronous, rst_n low) clears the parser state and empties the output register.
// The stack memory is not cleared; every entry is written by its push before it is read.
module bencode_stream_tokenizer #(
  parameter int MAX_DEPTH   = 32,
  parameter int LENGTH_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bst_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bst_pkg::out_item_t  out_data
);

  // Depth counter holds 0..MAX_DEPTH; the memory address only indexes entries.
  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // Parser phases.
  localparam logic [2:0] PH_EXPECT     = 3'd0;
  localparam logic [2:0] PH_INT_FIRST  = 3'd1;
  localparam logic [2:0] PH_INT_DIGITS = 3'd2;
  localparam logic [2:0] PH_LEN_DIGITS = 3'd3;
  localparam logic [2:0] PH_STRING     = 3'd4;
  localparam logic [2:0] PH_DONE       = 3'd5;
  localparam logic [2:0] PH_ERROR      = 3'd6;

  // Parser state registers.
  logic [2:0]             phase_r, phase_nxt;
  logic [DW-1:0]          depth_r, depth_nxt;
  logic                   top_dict_r, top_dict_nxt;
  logic                   top_key_r, top_key_nxt;
  logic [62:0]            acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  logic                   seen_r, seen_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;

  // Stack memory: each entry is {is dictionary, next entry is a key}. The entry on top
  // of the stack is held in top_dict_r/top_key_r; the memory holds everything beneath it.
  logic [1:0]    stack_mem [MAX_DEPTH];
  logic [1:0]    under_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          push;

  // Output register.
  logic               out_valid_r;
  bst_pkg::out_item_t out_data_r;
  bst_pkg::out_item_t result;

  logic take;

  // Effective state for this byte, with a message start folded in.
  logic [2:0]             ph;
  logic [DW-1:0]          dep;
  logic [62:0]            acc;
  logic                   neg;
  logic                   seen;
  logic [LENGTH_BITS-1:0] rem;
  logic                   in_dict;
  logic                   key_pos;
  logic                   is_digit;
  logic [3:0]             digit;
  logic [66:0]            sum;
  logic                   mag_ovf;
  logic                   len_ovf;
  logic [7:0]             b;

  // A new byte is taken whenever the output register is free or being emptied.
  assign in_stall  = out_valid_r & out_stall;
  assign take      = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    b        = in_data.data_byte;
    ph       = in_data.message_start ? PH_EXPECT : phase_r;
    dep      = in_data.message_start ? '0 : depth_r;
    acc      = in_data.message_start ? '0 : acc_r;
    neg      = in_data.message_start ? 1'b0 : neg_r;
    seen     = in_data.message_start ? 1'b0 : seen_r;
    rem      = in_data.message_start ? '0 : rem_r;
    in_dict  = (dep != '0) && top_dict_r;
    key_pos  = in_dict && top_key_r;
    is_digit = (b >= bst_pkg::CH_ZERO) && (b <= bst_pkg::CH_NINE);
    digit    = 4'(b - bst_pkg::CH_ZERO);
    // acc * 10 + digit as two shifted adds; overflow is any set bit above the allowed width.
    sum      = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 67'(digit);
    mag_ovf  = |sum[66:63];
    len_ovf  = |sum[66:LENGTH_BITS];

    phase_nxt    = ph;
    depth_nxt    = dep;
    top_dict_nxt = top_dict_r;
    top_key_nxt  = top_key_r;
    acc_nxt      = acc;
    neg_nxt      = neg;
    seen_nxt     = seen;
    rem_nxt      = rem;
    push         = 1'b0;

    result             = '0;
    result.event_kind  = bst_pkg::EV_NONE;
    result.error_code  = bst_pkg::ERR_NONE;

    unique case (ph) inside
      PH_EXPECT: begin
        if (b == bst_pkg::CH_END) begin
          if ((dep != '0) && (!in_dict || key_pos)) begin
            // Pop: the prefetched entry beneath becomes the new top, and the value
            // it was waiting for (the closed container) is finished.
            depth_nxt         = dep - DW'(1);
            top_dict_nxt      = under_r[1];
            top_key_nxt       = under_r[0];
            result.event_kind = bst_pkg::EV_CLOSE;
            if (depth_nxt == '0) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_EXPECT;
              if (under_r[1]) begin
                top_key_nxt = ~under_r[0];
              end
            end
          end else begin
            phase_nxt         = PH_ERROR;
            result.event_kind = bst_pkg::EV_ERROR;
            result.error_code = bst_pkg::ERR_UNEXPECTED;
          end
        end else if (key_pos && !is_digit) begin
          phase_nxt         = PH_ERROR;
          result.event_kind = bst_pkg::EV_ERROR;
          result.error_code = bst_pkg::ERR_UNEXPECTED;
        end else if ((b == bst_pkg::CH_DICT) || (b == bst_pkg::CH_LIST)) begin
          if (dep >= DW'(MAX_DEPTH)) begin
            phase_nxt         = PH_ERROR;
            result.event_kind = bst_pkg::EV_ERROR;
            result.error_code = bst_pkg::ERR_TOO_DEEP;
          end else begin
            push              = 1'b1;
            depth_nxt         = dep + DW'(1);
            top_dict_nxt      = (b == bst_pkg::CH_DICT);
            top_key_nxt       = (b == bst_pkg::CH_DICT);
            result.event_kind = (b == bst_pkg::CH_DICT) ? bst_pkg::EV_DICT_OPEN
                                                        : bst_pkg::EV_LIST_OPEN;
          end
        end else if (b == bst_pkg::CH_INT) begin
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
          seen_nxt  = 1'b0;
          phase_nxt = PH_INT_FIRST;
        end else if (is_digit) begin
          acc_nxt   = 63'(digit);
          neg_nxt   = 1'b0;
          seen_nxt  = 1'b1;
          phase_nxt = PH_LEN_DIGITS;
        end else begin
          phase_nxt         = PH_ERROR;
          result.event_kind = bst_pkg::EV_ERROR;
          result.error_code = bst_pkg::ERR_UNEXPECTED;
        end
      end

      PH_INT_FIRST, PH_INT_DIGITS: begin
        if ((ph == PH_INT_FIRST) && (b == bst_pkg::CH_MINUS)) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_INT_DIGITS;
        end else if (is_digit) begin
          if (mag_ovf) begin
            phase_nxt         = PH_ERROR;
            result.event_kind = bst_pkg::EV_ERROR;
            result.error_code = bst_pkg::ERR_OVERFLOW;
          end else begin
            acc_nxt   = sum[62:0];
            seen_nxt  = 1'b1;
            phase_nxt = PH_INT_DIGITS;
          end
        end else if (b == bst_pkg::CH_END) begin
          if (!seen) begin
            phase_nxt         = PH_ERROR;
            result.event_kind = bst_pkg::EV_ERROR;
            result.error_code = bst_pkg::ERR_NO_DIGITS;
          end else begin
            result.event_kind  = bst_pkg::EV_INTEGER;
            result.event_value = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
            if (dep == '0) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_EXPECT;
              if (in_dict) begin
                top_key_nxt = ~top_key_r;
              end
            end
          end
        end else begin
          phase_nxt         = PH_ERROR;
          result.event_kind = bst_pkg::EV_ERROR;
          result.error_code = bst_pkg::ERR_UNEXPECTED;
        end
      end

      PH_LEN_DIGITS: begin
        if (is_digit) begin
          if (len_ovf) begin
            phase_nxt         = PH_ERROR;
            result.event_kind = bst_pkg::EV_ERROR;
            result.error_code = bst_pkg::ERR_OVERFLOW;
          end else begin
            acc_nxt  = sum[62:0];
            seen_nxt = 1'b1;
          end
        end else if (b == bst_pkg::CH_COLON) begin
          result.event_kind  = bst_pkg::EV_STR_HDR;
          result.event_value = $signed({1'b0, acc});
          result.is_dict_key = key_pos;
          if (acc == '0) begin
            // An empty string is finished by its header.
            result.string_last = 1'b1;
            if (dep == '0) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_EXPECT;
              if (in_dict) begin
                top_key_nxt = ~top_key_r;
              end
            end
          end else begin
            rem_nxt   = acc[LENGTH_BITS-1:0];
            phase_nxt = PH_STRING;
          end
        end else begin
          phase_nxt         = PH_ERROR;
          result.event_kind = bst_pkg::EV_ERROR;
          result.error_code = bst_pkg::ERR_UNEXPECTED;
        end
      end

      PH_STRING: begin
        result.event_kind  = bst_pkg::EV_STR_BYTE;
        result.event_value = $signed({56'b0, b});
        result.is_dict_key = key_pos;
        rem_nxt            = rem - LENGTH_BITS'(1);
        if (rem == LENGTH_BITS'(1)) begin
          result.string_last = 1'b1;
          if (dep == '0) begin
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_EXPECT;
            if (in_dict) begin
              top_key_nxt = ~top_key_r;
            end
          end
        end
      end

      default: begin
        // Done or error: bytes are ignored until a message start.
      end
    endcase

    result.nesting_depth  = 6'(depth_nxt);
    result.value_complete = (phase_nxt == PH_DONE);
  end

  // The entry beneath the next top is read every cycle. A push writes the old top to
  // exactly the address being read, so that case is forwarded instead of read.
  always_comb begin
    logic [DW-1:0] depth_eff;
    depth_eff = take ? depth_nxt : depth_r;
    if (depth_eff >= DW'(2)) begin
      rd_addr = AW'(depth_eff - DW'(2));
    end else begin
      rd_addr = '0;
    end
    wr_addr = AW'(dep - DW'(1));
  end

  always_ff @(posedge clk) begin
    if (take && push && (dep != '0)) begin
      stack_mem[wr_addr] <= {top_dict_r, top_key_r};
    end
  end

  always_ff @(posedge clk) begin
    if (take && push) begin
      under_r <= {top_dict_r, top_key_r};
    end else begin
      under_r <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_EXPECT;
      depth_r    <= '0;
      top_dict_r <= 1'b0;
      top_key_r  <= 1'b0;
      acc_r      <= '0;
      neg_r      <= 1'b0;
      seen_r     <= 1'b0;
      rem_r      <= '0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      depth_r    <= depth_nxt;
      top_dict_r <= top_dict_nxt;
      top_key_r  <= top_key_nxt;
      acc_r      <= acc_nxt;
      neg_r      <= neg_nxt;
      seen_r     <= seen_nxt;
      rem_r      <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= result;
    end
  end

`ifndef ASSERT_OFF
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_DEPTH))
    else $error("stack depth above its bound");

  a_string_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STRING) |-> (rem_r != '0))
    else $error("string phase with no bytes remaining");

  a_done_at_top: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> (depth_r == '0))
    else $error("value complete with open containers");

  a_take_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("accepted byte produced no result");

  a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.event_kind == bst_pkg::EV_ERROR))
      |-> (out_data_r.error_code != bst_pkg::ERR_NONE))
    else $error("error event without an error code");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the bencode stream tokenizer: byte stimulus, event predictor, checker.
`timescale 1ns / 1ps

module testbench;

  // The block is built with its default sizes: 32 levels of nesting, 32-bit string lengths.
  localparam int          NEST_LIMIT   = 32;
  localparam logic [63:0] INT_MAG_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LEN_MAX      = 64'h0000_0000_FFFF_FFFF;
  localparam int          TOTAL_BYTES  = 1500;
  localparam int          HOLD_CYCLES  = 150;
  localparam int          DRAIN_CYCLES = 4;
  localparam longint      RUN_LIMIT_NS = 64'd10_000_000;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  bst_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bst_pkg::out_item_t out_data;

  bencode_stream_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Shared between the stimulus side, the receiver and the checker. Each variable has exactly
  // one writing process, except predicted_events: the sender fills it, the checker drains it.
  bst_pkg::out_item_t predicted_events[$];
  logic [7:0]         stream_bytes[$];
  int unsigned        bytes_sent  = 0;
  int unsigned        mismatches  = 0;
  int unsigned        hold_order  = 0;
  bit                 idling      = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------------
  // Event predictor. It tracks the parser exactly as the block should: which token it is in the
  // middle of, the container stack (kind and whether a dictionary wants a key next), the number
  // being accumulated and how many string bytes are still owed.
  // ---------------------------------------------------------------------------------------------
  typedef enum logic [2:0] {
    AWAIT_VALUE, INT_OPEN, INT_BODY, LEN_BODY, STR_BODY, MSG_DONE, MSG_FAILED
  } parse_state_t;

  parse_state_t pstate;
  logic         frame_is_dict   [NEST_LIMIT];
  logic         frame_wants_key [NEST_LIMIT];
  int unsigned  depth;
  logic [63:0]  accum;
  logic         negative;
  logic         have_digit;
  logic [63:0]  left_in_str;

  function automatic void reset_parser();
    pstate      = AWAIT_VALUE;
    depth       = 0;
    accum       = '0;
    negative    = 1'b0;
    have_digit  = 1'b0;
    left_in_str = '0;
  endfunction

  function automatic logic in_dict();
    return depth > 0 && frame_is_dict[depth - 1];
  endfunction

  function automatic logic at_key();
    return in_dict() && frame_wants_key[depth - 1];
  endfunction

  // A finished value either completes the message or flips a dictionary between key and value.
  function automatic void finish_value();
    if (depth == 0) begin
      pstate = MSG_DONE;
    end else begin
      if (in_dict()) frame_wants_key[depth - 1] ^= 1'b1;
      pstate = AWAIT_VALUE;
    end
  endfunction

  function automatic void clear_number();
    accum      = '0;
    negative   = 1'b0;
    have_digit = 1'b0;
  endfunction

  // Adds one decimal digit unless the result would pass the limit; overflow leaves accum alone.
  function automatic logic push_digit(logic [63:0] limit, logic [63:0] digit);
    if (accum > (limit - digit) / 64'd10) return 1'b0;
    accum      = accum * 64'd10 + digit;
    have_digit = 1'b1;
    return 1'b1;
  endfunction

  function automatic bst_pkg::out_item_t failure(logic [2:0] code);
    bst_pkg::out_item_t r;
    r            = '0;
    r.event_kind = bst_pkg::EV_ERROR;
    r.error_code = code;
    pstate       = MSG_FAILED;
    return r;
  endfunction

  // Works out the event for one accepted byte and advances the predicted parser state.
  function automatic bst_pkg::out_item_t tokenize_byte(bst_pkg::in_item_t item);
    bst_pkg::out_item_t r;
    logic [7:0]         b;
    logic               is_digit;
    logic [63:0]        digit;
    b        = item.data_byte;
    is_digit = b >= bst_pkg::CH_ZERO && b <= bst_pkg::CH_NINE;
    digit    = {60'd0, b[3:0]};
    r        = '0;
    if (item.message_start) reset_parser();
    case (pstate) inside
      AWAIT_VALUE: begin
        if (b == bst_pkg::CH_END) begin
          // A close is legal where a list item or a dictionary key could start.
          if (depth > 0 && (!in_dict() || at_key())) begin
            depth--;
            r.event_kind = bst_pkg::EV_CLOSE;
            finish_value();
          end else begin
            r = failure(bst_pkg::ERR_UNEXPECTED);
          end
        end else if (at_key() && !is_digit) begin
          r = failure(bst_pkg::ERR_UNEXPECTED);
        end else if (b == bst_pkg::CH_DICT || b == bst_pkg::CH_LIST) begin
          if (depth >= NEST_LIMIT) begin
            r = failure(bst_pkg::ERR_TOO_DEEP);
          end else begin
            frame_is_dict[depth]   = (b == bst_pkg::CH_DICT);
            frame_wants_key[depth] = (b == bst_pkg::CH_DICT);
            depth++;
            r.event_kind = (b == bst_pkg::CH_DICT) ? bst_pkg::EV_DICT_OPEN
                                                   : bst_pkg::EV_LIST_OPEN;
          end
        end else if (b == bst_pkg::CH_INT) begin
          clear_number();
          pstate = INT_OPEN;
        end else if (is_digit) begin
          clear_number();
          void'(push_digit(LEN_MAX, digit));
          pstate = LEN_BODY;
        end else begin
          r = failure(bst_pkg::ERR_UNEXPECTED);
        end
      end
      INT_OPEN, INT_BODY: begin
        if (pstate == INT_OPEN && b == bst_pkg::CH_MINUS) begin
          negative = 1'b1;
          pstate   = INT_BODY;
        end else if (is_digit) begin
          pstate = INT_BODY;
          if (!push_digit(INT_MAG_MAX, digit)) r = failure(bst_pkg::ERR_OVERFLOW);
        end else if (b == bst_pkg::CH_END) begin
          if (!have_digit) begin
            r = failure(bst_pkg::ERR_NO_DIGITS);
          end else begin
            r.event_kind  = bst_pkg::EV_INTEGER;
            r.event_value = negative ? (64'd0 - accum) : accum;
            finish_value();
          end
        end else begin
          r = failure(bst_pkg::ERR_UNEXPECTED);
        end
      end
      LEN_BODY: begin
        if (is_digit) begin
          if (!push_digit(LEN_MAX, digit)) r = failure(bst_pkg::ERR_OVERFLOW);
        end else if (b == bst_pkg::CH_COLON) begin
          r.event_kind  = bst_pkg::EV_STR_HDR;
          r.event_value = accum;
          r.is_dict_key = at_key();
          if (accum == 0) begin
            r.string_last = 1'b1;
            finish_value();
          end else begin
            left_in_str = accum;
            pstate      = STR_BODY;
          end
        end else begin
          r = failure(bst_pkg::ERR_UNEXPECTED);
        end
      end
      STR_BODY: begin
        r.event_kind  = bst_pkg::EV_STR_BYTE;
        r.event_value = {56'd0, b};
        r.is_dict_key = at_key();
        left_in_str--;
        if (left_in_str == 0) begin
          r.string_last = 1'b1;
          finish_value();
        end
      end
      default: begin
        // Done or failed: bytes are swallowed until the next message start.
      end
    endcase
    r.nesting_depth  = depth[5:0];
    r.value_complete = (pstate == MSG_DONE);
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Sending side. Gaps are mostly short with the odd long one, and switch off entirely while
  // idling is clear so that back-to-back stretches are covered as well.
  // ---------------------------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    if (!idling) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 2);
    if (roll < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // Offers one byte and returns at the edge where the block takes it. Valid is left high so
  // the next item can follow in the very next cycle; it drops only for a gap.
  task automatic send_byte(logic [7:0] b, logic start);
    bst_pkg::in_item_t item;
    int                gap;
    item.data_byte     = b;
    item.message_start = start;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predicted_events.push_back(tokenize_byte(item));
    bytes_sent++;
  endtask

  // Sends the staged bytes as one message; only the first byte may carry message_start.
  task automatic send_stream(logic first_start);
    foreach (stream_bytes[i]) send_byte(stream_bytes[i], (i == 0) ? first_start : 1'b0);
    stream_bytes.delete();
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) stream_bytes.push_back(s[i]);
  endtask

  task automatic put_number(logic [63:0] mag, int zeros);
    string digits;
    digits = $sformatf("%0d", mag);
    repeat (zeros) stream_bytes.push_back(bst_pkg::CH_ZERO);
    for (int i = 0; i < digits.len(); i++) stream_bytes.push_back(digits[i]);
  endtask

  task automatic gen_int();
    logic [63:0] mag;
    case ($urandom_range(0, 7))
      0:       mag = '0;
      1:       mag = INT_MAG_MAX;
      2:       mag = 64'($urandom_range(0, 9));
      default: mag = {$urandom, $urandom} >> $urandom_range(1, 63);
    endcase
    stream_bytes.push_back(bst_pkg::CH_INT);
    if ($urandom_range(0, 2) == 0) stream_bytes.push_back(bst_pkg::CH_MINUS);
    put_number(mag, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
    stream_bytes.push_back(bst_pkg::CH_END);
  endtask

  // String bytes cover the whole byte range, so every data bit toggles.
  task automatic gen_string(int maxlen);
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, maxlen);
    put_number(64'(len), ($urandom_range(0, 9) == 0) ? 1 : 0);
    stream_bytes.push_back(bst_pkg::CH_COLON);
    repeat (len) stream_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Builds one well-formed value. Below the dive level it always opens a container whose
  // first child continues the dive, which is how the deep nesting cases are reached.
  task automatic gen_value(int lvl, int dive);
    int pick;
    int n;
    if (lvl < dive) pick = $urandom_range(2, 3);
    else pick = $urandom_range(0, (lvl < 3) ? 3 : 1);
    case (pick)
      0: gen_int();
      1: gen_string(6);
      default: begin
        stream_bytes.push_back((pick == 2) ? bst_pkg::CH_LIST : bst_pkg::CH_DICT);
        n = (lvl < dive) ? $urandom_range(1, 2) : $urandom_range(0, (lvl == 0) ? 4 : 2);
        for (int k = 0; k < n; k++) begin
          if (pick == 3) gen_string(4);
          gen_value(lvl + 1, (k == 0) ? dive : 0);
        end
        stream_bytes.push_back(bst_pkg::CH_END);
      end
    endcase
  endtask

  // Most messages go out intact; the rest get one byte replaced, get cut short (the next
  // message start then aborts them) or are plain noise. Some carry ignored trailing bytes.
  task automatic build_message(int dive);
    int roll;
    int pos;
    gen_value(0, dive);
    roll = $urandom_range(0, 19);
    if (roll >= 15 && roll <= 16) begin
      pos = $urandom_range(0, stream_bytes.size() - 1);
      case ($urandom_range(0, 7))
        0:       stream_bytes[pos] = bst_pkg::CH_END;
        1:       stream_bytes[pos] = bst_pkg::CH_COLON;
        2:       stream_bytes[pos] = bst_pkg::CH_MINUS;
        3:       stream_bytes[pos] = bst_pkg::CH_DICT;
        4:       stream_bytes[pos] = bst_pkg::CH_LIST;
        5:       stream_bytes[pos] = bst_pkg::CH_INT;
        6:       stream_bytes[pos] = bst_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        default: stream_bytes[pos] = 8'($urandom_range(0, 255));
      endcase
    end else if (roll >= 17 && roll <= 18 && stream_bytes.size() > 1) begin
      pos = $urandom_range(1, stream_bytes.size() - 1);
      while (stream_bytes.size() > pos) void'(stream_bytes.pop_back());
    end else if (roll == 19) begin
      stream_bytes.delete();
      repeat ($urandom_range(1, 5)) stream_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) stream_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------------

  // Every event kind, the no-digits and unexpected-byte errors, plus bytes arriving after
  // completion and after an error without a new message start.
  task automatic test_basic_tokens();
    idling = 1'b1;
    put_text("d1:ai-0ee");  // dictionary, key string, minus zero, close, completion
    send_stream(1'b1);
    put_text("x");          // trailing byte after a complete value is ignored
    send_stream(1'b0);
    put_text("0:");         // empty string at the top level
    send_stream(1'b1);
    put_text("le");
    send_stream(1'b1);
    put_text("ie");         // integer with no digits
    send_stream(1'b1);
    put_text("7");          // swallowed after the error
    send_stream(1'b0);
    put_text("di");         // only a string may start at a key position
    send_stream(1'b1);
    put_text("e");          // close at the top level
    send_stream(1'b1);
    put_text("d1:ke");      // close where a dictionary value is due
    send_stream(1'b1);
  endtask

  // Integers and string lengths around their limits, with random sign, leading zeros and
  // sometimes a surrounding list. Even rounds are integers, odd rounds string headers; the
  // first rounds of each hit the exact maximum and one past it.
  task automatic test_number_limits();
    logic [63:0] mag;
    logic        wrap;
    for (int k = 0; k < 16; k++) begin
      wrap = 1'($urandom_range(0, 1));
      if (wrap) stream_bytes.push_back(bst_pkg::CH_LIST);
      if (k % 2 == 0) begin
        mag = INT_MAG_MAX - 64'd2 +
              ((k == 0) ? 64'd2 : (k == 2) ? 64'd3 : 64'($urandom_range(0, 4)));
        stream_bytes.push_back(bst_pkg::CH_INT);
        if (k == 6 || $urandom_range(0, 1) == 1) stream_bytes.push_back(bst_pkg::CH_MINUS);
        // A bare minus sign followed by the end marker has no digits.
        if (k != 6) put_number(mag, $urandom_range(0, 2));
        // An extra digit pushes the magnitude past the limit by a factor of ten.
        if (k == 4) stream_bytes.push_back(bst_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        stream_bytes.push_back(bst_pkg::CH_END);
      end else begin
        mag = LEN_MAX - 64'd2 +
              ((k == 1) ? 64'd2 : (k == 3) ? 64'd3 : 64'($urandom_range(0, 4)));
        put_number(mag, $urandom_range(0, 2));
        stream_bytes.push_back(bst_pkg::CH_COLON);
        // The body of such a string can never be sent in full; the next start cuts it short.
        repeat ($urandom_range(0, 3)) stream_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (wrap) stream_bytes.push_back(bst_pkg::CH_END);
      send_stream(1'b1);
    end
  endtask

  // One below the limit, exactly at it, and one past it, which must report nesting too deep.
  // Each level is a list or a dictionary with a short key, with one integer at the bottom.
  task automatic test_deep_nesting();
    for (int d = NEST_LIMIT - 1; d <= NEST_LIMIT + 1; d++) begin
      for (int k = 0; k < d; k++) begin
        if ($urandom_range(0, 1) == 1) begin
          stream_bytes.push_back(bst_pkg::CH_DICT);
          put_text("1:k");
        end else begin
          stream_bytes.push_back(bst_pkg::CH_LIST);
        end
      end
      put_text("i7e");
      repeat (d) stream_bytes.push_back(bst_pkg::CH_END);
      send_stream(1'b1);
    end
  endtask

  // The receiver holds off for a long stretch while a long list streams in without gaps, so
  // the block fills up and has to stall its input.
  task automatic test_backpressure();
    idling = 1'b0;
    hold_order++;
    stream_bytes.push_back(bst_pkg::CH_LIST);
    repeat (20) gen_string(6);
    stream_bytes.push_back(bst_pkg::CH_END);
    send_stream(1'b1);
  endtask

  // Random messages, some diving to the nesting limit, with idling switched on and off in
  // stretches, until the whole run has sent its share of bytes.
  task automatic test_random_streams();
    idling = 1'b1;
    while (bytes_sent < TOTAL_BYTES) begin
      if ($urandom_range(0, 9) == 0) idling = !idling;
      build_message(($urandom_range(0, 11) == 0) ? $urandom_range(26, NEST_LIMIT + 1) : 0);
      send_stream(1'b1);
    end
  endtask

  initial begin
    reset_parser();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_tokens();
    test_number_limits();
    test_deep_nesting();
    test_backpressure();
    test_random_streams();
    in_valid <= 1'b0;
    while (predicted_events.size() != 0) @(posedge clk);
    // The extra drain wait catches any stray event left in the event register.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------------------------
  // Receiving side. A new hold order from the backpressure test starts a long stall counted
  // here; otherwise stalls of random length come and go while idling is set.
  // ---------------------------------------------------------------------------------------------
  initial begin
    int unsigned served;
    int          left;
    served = 0;
    left   = 0;
    forever begin
      @(posedge clk);
      if (hold_order != served) begin
        served = hold_order;
        left   = HOLD_CYCLES;
      end else if (left == 0 && idling && $urandom_range(0, 2) == 0) begin
        left = pick_gap();
      end
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Every event taken from the block is matched against the oldest prediction, field by field.
  initial begin
    bst_pkg::out_item_t got;
    bst_pkg::out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = out_data;
        if (predicted_events.size() == 0) begin
          $error("event of kind %0d with no byte outstanding", got.event_kind);
          mismatches++;
        end else begin
          want = predicted_events.pop_front();
          compare_field("event_kind", 64'(want.event_kind), 64'(got.event_kind));
          compare_field("event_value", want.event_value, got.event_value);
          compare_field("is_dict_key", 64'(want.is_dict_key), 64'(got.is_dict_key));
          compare_field("nesting_depth", 64'(want.nesting_depth), 64'(got.nesting_depth));
          compare_field("string_last", 64'(want.string_last), 64'(got.string_last));
          compare_field("error_code", 64'(want.error_code), 64'(got.error_code));
          compare_field("value_complete", 64'(want.value_complete), 64'(got.value_complete));
        end
      end
    end
  end

  // Hang guard, far above the slowest legal run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bst_pkg.sv
design/bencode_stream_tokenizer.sv
tb/testbench.sv
